// ===== sv/cbc_pkg.sv =====
// Shared types, constants and helpers of the comment and blank classifier.
package cbc_pkg;

  localparam int LINE_BITS   = 24;
  localparam int COLUMN_BITS = 16;

  // Packed result payload on the output stream.
  localparam int TDATA_BITS = 8 + LINE_BITS + COLUMN_BITS;
  localparam int TDATA_W    = ((TDATA_BITS + 7) / 8) * 8;
  localparam int TUSER_W    = 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;

  typedef enum logic [1:0] {
    KIND_SIG   = 2'd0,
    KIND_BLANK = 2'd1,
    KIND_LINE  = 2'd2,
    KIND_BLOCK = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0]             ch;
    kind_e                  kind;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic                   unterm;
    logic                   last;
  } result_t;

  // One or two results caused by a single input byte.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } pair_t;

  function automatic logic [COLUMN_BITS-1:0] col_inc(input logic [COLUMN_BITS-1:0] c);
    col_inc = (c == {COLUMN_BITS{1'b1}}) ? c : c + 1'b1;
  endfunction

  function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] l);
    line_inc = (l == {LINE_BITS{1'b1}}) ? l : l + 1'b1;
  endfunction

endpackage

// ===== sv/cbc_front.sv =====
// Front end: accepts text bytes, runs the scan state machine and builds result pairs.
module cbc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  logic [7:0]      byte_i,
  input  logic            eot_i,
  input  logic            full_i,
  output logic            push_o,
  output cbc_pkg::pair_t  pair_o
);

  localparam logic [2:0] MODE_NORMAL     = 3'd0;
  localparam logic [2:0] MODE_HELD       = 3'd1;
  localparam logic [2:0] MODE_LINE       = 3'd2;
  localparam logic [2:0] MODE_BLOCK      = 3'd3;
  localparam logic [2:0] MODE_BLOCK_STAR = 3'd4;

  logic [2:0]                      mode_q, mode_d;
  logic [cbc_pkg::LINE_BITS-1:0]   line_q, line_d;
  logic [cbc_pkg::COLUMN_BITS-1:0] col_q, col_d;
  logic [cbc_pkg::COLUMN_BITS-1:0] held_q, held_d;
  logic [1:0]                      cnt;
  logic                            accept;
  logic                            is_nl;
  logic                            is_cont;
  cbc_pkg::kind_e                  norm_kind;
  cbc_pkg::pair_t                  pair;

  assign s_ready_o = !full_i;
  assign accept    = s_valid_i && s_ready_o;
  assign is_nl     = (byte_i == cbc_pkg::CH_NEWLINE);
  assign is_cont   = (byte_i[7:6] == 2'b10);
  assign norm_kind = (byte_i <= cbc_pkg::CH_SPACE) ? cbc_pkg::KIND_BLANK : cbc_pkg::KIND_SIG;

  always_comb begin
    mode_d = mode_q;
    line_d = line_q;
    col_d  = col_q;
    held_d = held_q;
    cnt    = 2'd1;
    pair.two       = 1'b0;
    pair.r0.ch     = byte_i;
    pair.r0.kind   = cbc_pkg::KIND_SIG;
    pair.r0.line   = line_q;
    pair.r0.col    = col_q;
    pair.r0.unterm = 1'b0;
    pair.r0.last   = 1'b0;
    pair.r1        = pair.r0;

    unique case (mode_q)
      MODE_HELD: begin
        // The held slash always goes out first, at the column where it started.
        pair.r0.ch  = cbc_pkg::CH_SLASH;
        pair.r0.col = held_q;
        cnt         = 2'd2;
        if (byte_i == cbc_pkg::CH_SLASH) begin
          pair.r0.kind = cbc_pkg::KIND_LINE;
          pair.r1.kind = cbc_pkg::KIND_LINE;
          col_d        = cbc_pkg::col_inc(col_q);
          mode_d       = MODE_LINE;
        end else if (byte_i == cbc_pkg::CH_STAR) begin
          pair.r0.kind = cbc_pkg::KIND_BLOCK;
          pair.r1.kind = cbc_pkg::KIND_BLOCK;
          col_d        = cbc_pkg::col_inc(col_q);
          mode_d       = MODE_BLOCK;
        end else begin
          pair.r0.kind = cbc_pkg::KIND_SIG;
          pair.r1.kind = norm_kind;
          mode_d       = MODE_NORMAL;
          if (is_nl) begin
            line_d = cbc_pkg::line_inc(line_q);
            col_d  = '0;
          end else begin
            col_d  = cbc_pkg::col_inc(col_q);
          end
        end
      end
      MODE_LINE: begin
        pair.r0.kind = cbc_pkg::KIND_LINE;
        if (is_nl) begin
          line_d = cbc_pkg::line_inc(line_q);
          col_d  = '0;
          mode_d = MODE_NORMAL;
        end else begin
          col_d  = cbc_pkg::col_inc(col_q);
        end
      end
      MODE_BLOCK, MODE_BLOCK_STAR: begin
        pair.r0.kind = cbc_pkg::KIND_BLOCK;
        if (mode_q == MODE_BLOCK_STAR && byte_i == cbc_pkg::CH_SLASH) begin
          mode_d = MODE_NORMAL;
        end else if (byte_i == cbc_pkg::CH_STAR) begin
          mode_d = MODE_BLOCK_STAR;
        end else begin
          mode_d = MODE_BLOCK;
        end
        // Continuation bytes of a multi-byte character share the lead byte's column.
        if (is_nl) begin
          line_d = cbc_pkg::line_inc(line_q);
          col_d  = '0;
        end else if (!is_cont) begin
          col_d  = cbc_pkg::col_inc(col_q);
        end
      end
      default: begin
        if (byte_i == cbc_pkg::CH_SLASH && !eot_i) begin
          held_d = col_q;
          col_d  = cbc_pkg::col_inc(col_q);
          mode_d = MODE_HELD;
          cnt    = 2'd0;
        end else begin
          pair.r0.kind = norm_kind;
          mode_d       = MODE_NORMAL;
          if (is_nl) begin
            line_d = cbc_pkg::line_inc(line_q);
            col_d  = '0;
          end else begin
            col_d  = cbc_pkg::col_inc(col_q);
          end
        end
      end
    endcase

    pair.two = (cnt == 2'd2);

    if (eot_i) begin
      if (pair.two) begin
        pair.r1.last   = 1'b1;
        pair.r1.unterm = (mode_d == MODE_BLOCK) || (mode_d == MODE_BLOCK_STAR);
      end else begin
        pair.r0.last   = 1'b1;
        pair.r0.unterm = (mode_d == MODE_BLOCK) || (mode_d == MODE_BLOCK_STAR);
      end
      // The next byte starts a fresh text.
      mode_d = MODE_NORMAL;
      line_d = '0;
      col_d  = '0;
      held_d = '0;
    end
  end

  assign push_o = accept && (cnt != 2'd0);
  assign pair_o = pair;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      line_q <= '0;
      col_q  <= '0;
      held_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      line_q <= line_d;
      col_q  <= col_d;
      held_q <= held_d;
    end
  end

endmodule

// ===== sv/cbc_queue.sv =====
// Short queue of result pairs between the front end and the output stage.
module cbc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cbc_pkg::pair_t  wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output cbc_pkg::pair_t  rdata_o,
  output logic            empty_o
);

  localparam logic [cbc_pkg::QUEUE_AW:0] DEPTH_C = (cbc_pkg::QUEUE_AW + 1)'(cbc_pkg::QUEUE_DEPTH);

  cbc_pkg::pair_t                  mem_q [cbc_pkg::QUEUE_DEPTH];
  logic [cbc_pkg::QUEUE_AW-1:0]    wr_q, rd_q;
  logic [cbc_pkg::QUEUE_AW:0]      count_q;
  logic                            do_push, do_pop;

  assign full_o  = (count_q == DEPTH_C);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ===== sv/cbc_back.sv =====
// Output stage: unpacks result pairs and presents one result a cycle while the receiver is ready.
module cbc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  cbc_pkg::pair_t    rdata_i,
  output logic              pop_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output cbc_pkg::result_t  res_o
);

  logic              out_valid_q;
  logic              pend_q;
  cbc_pkg::result_t  out_q;
  cbc_pkg::result_t  second_q;
  logic              adv;

  assign adv       = !out_valid_q || m_ready_i;
  assign pop_o     = adv && !pend_q && !empty_i;
  assign m_valid_o = out_valid_q;
  assign res_o     = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (adv) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else if (!empty_i) begin
        out_valid_q <= 1'b1;
        pend_q      <= rdata_i.two;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (pend_q) begin
        out_q <= second_q;
      end else if (!empty_i) begin
        out_q    <= rdata_i.r0;
        second_q <= rdata_i.r1;
      end
    end
  end

endmodule

// ===== sv/comment_and_blank_classifier_top.sv =====
// Top level of the comment and blank classifier.
//
// Input stream: one source byte per request on s_axis_tdata, with s_axis_tlast
// marking the final byte of a text. Output stream: one classified byte per
// request, with its line and column, its kind and an unterminated flag in
// tuser, and m_axis_tlast on the last result caused by the final byte.
// A byte is taken every cycle while the internal four-entry pair queue has
// room. Most bytes give one result; a slash in normal text that is not the
// final byte is held until the next byte, and the byte after a held slash
// gives two results, which leave one after the other, so output runs at one
// result per cycle while the receiver is ready. Output valid rises after the
// input request is taken: the pair is written into the queue, then moved into
// the output register.
// When the receiver stalls, the output register holds its result,
// the queue fills and s_axis_tready drops once the queue is full.
// Reset clears the scan state to normal text at line 0, column 0, and
// empties the queue and the output stage.
module comment_and_blank_classifier_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] text_byte
  input  logic                        s_axis_tlast,   // end_of_text
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // From bit 0 up: out_byte, line_number, column_number.
  output logic [cbc_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [cbc_pkg::TUSER_W-1:0] m_axis_tuser,   // kind [1:0], unterminated [2]
  output logic                        m_axis_tlast    // final_result
);

  logic              push, full, pop, empty;
  cbc_pkg::pair_t    wpair, rpair;
  cbc_pkg::result_t  res;

  cbc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .byte_i    (s_axis_tdata),
    .eot_i     (s_axis_tlast),
    .full_i    (full),
    .push_o    (push),
    .pair_o    (wpair)
  );

  cbc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wpair),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (rpair),
    .empty_o (empty)
  );

  cbc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (empty),
    .rdata_i   (rpair),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .res_o     (res)
  );

  assign m_axis_tdata = cbc_pkg::TDATA_W'({res.col, res.line, res.ch});
  assign m_axis_tuser = {res.unterm, res.kind};
  assign m_axis_tlast = res.last;

endmodule

// ===== sv/cbc_checker.sv =====
// Port-level checks of the classifier, bound to the top level.
module cbc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [cbc_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic [cbc_pkg::TUSER_W-1:0] m_axis_tuser,
  input logic                        m_axis_tlast
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

  // An unterminated flag can only mark the final result of a text.
  a_unterm_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tlast)
    else $error("unterminated flag without final result");

  // The text ended inside a block comment, so that result is block comment.
  a_unterm_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == cbc_pkg::KIND_BLOCK)
    else $error("unterminated result is not block comment");

endmodule

bind comment_and_blank_classifier_top cbc_checker u_cbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== dv/tb_comment_and_blank_classifier_top.sv =====
// Self-checking testbench of the comment and blank classifier top level.
module tb_comment_and_blank_classifier_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_BYTES = 1700;

  typedef enum logic [2:0] {
    SCAN_NORMAL,
    SCAN_HELD,
    SCAN_LINE,
    SCAN_BLOCK,
    SCAN_BLOCK_STAR
  } scan_e;

  // Tracks the scan state of the text and holds the classified bytes still to come.
  class classifier_scoreboard;
    scan_e                           mode;
    logic [cbc_pkg::LINE_BITS-1:0]   line_cnt;
    logic [cbc_pkg::COLUMN_BITS-1:0] col_cnt;
    logic [cbc_pkg::COLUMN_BITS-1:0] held_col;
    cbc_pkg::result_t                step_results[$];
    cbc_pkg::result_t                expected_results[$];
    int                              mismatches;

    function new();
      clear_text();
      mismatches = 0;
    endfunction

    function void clear_text();
      mode     = SCAN_NORMAL;
      line_cnt = '0;
      col_cnt  = '0;
      held_col = '0;
    endfunction

    function void bump_col();
      if (col_cnt != '1) col_cnt = col_cnt + 1'b1;
    endfunction

    function void bump_line();
      if (line_cnt != '1) line_cnt = line_cnt + 1'b1;
      col_cnt = '0;
    endfunction

    function void emit(logic [7:0] ch, cbc_pkg::kind_e kind,
                       logic [cbc_pkg::COLUMN_BITS-1:0] col);
      cbc_pkg::result_t r;
      r.ch     = ch;
      r.kind   = kind;
      r.line   = line_cnt;
      r.col    = col;
      r.unterm = 1'b0;
      r.last   = 1'b0;
      step_results.push_back(r);
    endfunction

    // A slash in normal text is held back until the next byte shows what it opens.
    function void plain_byte(logic [7:0] b, logic eot);
      if (b == cbc_pkg::CH_SLASH && !eot) begin
        held_col = col_cnt;
        bump_col();
        mode = SCAN_HELD;
      end else begin
        if (b <= cbc_pkg::CH_SPACE) emit(b, cbc_pkg::KIND_BLANK, col_cnt);
        else emit(b, cbc_pkg::KIND_SIG, col_cnt);
        if (b == cbc_pkg::CH_NEWLINE) bump_line();
        else bump_col();
        mode = SCAN_NORMAL;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic eot);
      cbc_pkg::kind_e   opened;
      cbc_pkg::result_t tail;
      step_results.delete();
      case (mode)
        SCAN_HELD: begin
          if (b == cbc_pkg::CH_SLASH || b == cbc_pkg::CH_STAR) begin
            opened = (b == cbc_pkg::CH_SLASH) ? cbc_pkg::KIND_LINE : cbc_pkg::KIND_BLOCK;
            emit(cbc_pkg::CH_SLASH, opened, held_col);
            emit(b, opened, col_cnt);
            bump_col();
            mode = (b == cbc_pkg::CH_SLASH) ? SCAN_LINE : SCAN_BLOCK;
          end else begin
            emit(cbc_pkg::CH_SLASH, cbc_pkg::KIND_SIG, held_col);
            plain_byte(b, eot);
          end
        end
        SCAN_LINE: begin
          emit(b, cbc_pkg::KIND_LINE, col_cnt);
          if (b == cbc_pkg::CH_NEWLINE) begin
            bump_line();
            mode = SCAN_NORMAL;
          end else begin
            bump_col();
          end
        end
        SCAN_BLOCK, SCAN_BLOCK_STAR: begin
          emit(b, cbc_pkg::KIND_BLOCK, col_cnt);
          if (mode == SCAN_BLOCK_STAR && b == cbc_pkg::CH_SLASH) mode = SCAN_NORMAL;
          else mode = (b == cbc_pkg::CH_STAR) ? SCAN_BLOCK_STAR : SCAN_BLOCK;
          // UTF-8 continuation bytes share the column of their lead byte.
          if (b == cbc_pkg::CH_NEWLINE) bump_line();
          else if (b[7:6] != 2'b10) bump_col();
        end
        default: plain_byte(b, eot);
      endcase
      if (eot) begin
        if (step_results.size() > 0) begin
          tail        = step_results.pop_back();
          tail.last   = 1'b1;
          tail.unterm = (mode == SCAN_BLOCK || mode == SCAN_BLOCK_STAR);
          step_results.push_back(tail);
        end
        clear_text();
      end
      foreach (step_results[i]) expected_results.push_back(step_results[i]);
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatches++;
      $display("%0t ns: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    task check_result(logic [cbc_pkg::TDATA_W-1:0] data, logic [cbc_pkg::TUSER_W-1:0] user,
                      logic tlast);
      cbc_pkg::result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", data, 0);
      end else begin
        want = expected_results.pop_front();
        if (data[7:0] != want.ch) report_mismatch("out_byte", data[7:0], want.ch);
        if (user[1:0] != want.kind) report_mismatch("kind", user[1:0], want.kind);
        if (data[8 +: cbc_pkg::LINE_BITS] != want.line) begin
          report_mismatch("line_number", data[8 +: cbc_pkg::LINE_BITS], want.line);
        end
        if (data[8 + cbc_pkg::LINE_BITS +: cbc_pkg::COLUMN_BITS] != want.col) begin
          report_mismatch("column_number",
                          data[8 + cbc_pkg::LINE_BITS +: cbc_pkg::COLUMN_BITS], want.col);
        end
        if (user[2] != want.unterm) report_mismatch("unterminated", user[2], want.unterm);
        if (tlast != want.last) report_mismatch("final_result", tlast, want.last);
      end
    endtask

    task flush_check();
      if (expected_results.size() != 0) begin
        report_mismatch("results never delivered", 0, expected_results.size());
      end
    endtask
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata;
  logic                          s_axis_tlast;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [cbc_pkg::TDATA_W-1:0]   m_axis_tdata;
  logic [cbc_pkg::TUSER_W-1:0]   m_axis_tuser;
  logic                          m_axis_tlast;

  classifier_scoreboard board = new();
  bit                   calm = 1'b0;
  int unsigned          cycles = 0;
  int                   sent = 0;
  logic [7:0]           text_q[$];

  comment_and_blank_classifier_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // Mostly short gaps, now and then a long one, none at all while calm.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  initial begin : sink
    int hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (calm) begin
        m_axis_tready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
      end else if ($urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1'b1;
        hold = $urandom_range(0, 10);
      end else begin
        m_axis_tready <= 1'b0;
        hold = pick_gap();
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_byte(b, eot);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input bit close);
    foreach (text_q[i]) send_byte(text_q[i], close && (i == text_q.size() - 1));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic logic [7:0] block_filler();
    case ($urandom_range(0, 5))
      0:       return cbc_pkg::CH_STAR;
      1:       return cbc_pkg::CH_SLASH;
      2:       return 8'($urandom_range(8'h80, 8'hBF));
      3:       return 8'($urandom_range(8'hC0, 8'hFF));
      4:       return cbc_pkg::CH_NEWLINE;
      default: return 8'($urandom_range(8'h00, 8'h7F));
    endcase
  endfunction

  // Builds a text from tokens; some texts are cut short so they end in any scan mode.
  function automatic void build_text();
    int         keep;
    logic [7:0] c;
    text_q.delete();
    repeat ($urandom_range(1, 10)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(33, 126)));
        3: begin
          repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 3) == 0) text_q.push_back(cbc_pkg::CH_NEWLINE);
            else text_q.push_back(8'($urandom_range(0, 32)));
          end
        end
        4: begin
          text_q.push_back(cbc_pkg::CH_SLASH);
          text_q.push_back(cbc_pkg::CH_SLASH);
          repeat ($urandom_range(0, 10)) begin
            c = 8'($urandom_range(0, 255));
            text_q.push_back((c == cbc_pkg::CH_NEWLINE) ? cbc_pkg::CH_SPACE : c);
          end
          text_q.push_back(cbc_pkg::CH_NEWLINE);
        end
        5, 6: begin
          text_q.push_back(cbc_pkg::CH_SLASH);
          text_q.push_back(cbc_pkg::CH_STAR);
          repeat ($urandom_range(0, 12)) text_q.push_back(block_filler());
          text_q.push_back(cbc_pkg::CH_STAR);
          text_q.push_back(cbc_pkg::CH_SLASH);
        end
        7: begin
          text_q.push_back(cbc_pkg::CH_SLASH);
          text_q.push_back(8'($urandom_range(0, 255)));
        end
        8: text_q.push_back(8'($urandom_range(0, 255)));
        default: begin
          // Opener whose star sits right before a slash, then a star run that closes.
          text_q.push_back(cbc_pkg::CH_SLASH);
          text_q.push_back(cbc_pkg::CH_STAR);
          text_q.push_back(cbc_pkg::CH_SLASH);
          text_q.push_back(cbc_pkg::CH_STAR);
          text_q.push_back(cbc_pkg::CH_STAR);
          text_q.push_back(cbc_pkg::CH_SLASH);
        end
      endcase
    end
    if ($urandom_range(0, 2) == 0) begin
      keep = $urandom_range(1, text_q.size());
      while (text_q.size() > keep) void'(text_q.pop_back());
    end
  endfunction

  initial begin : stimulus
    bit paused;
    paused        = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Blanks, high bytes, a released slash, a line comment, an opener star that
    // must not close, continuation bytes, a close, and a slash as final byte.
    text_q = '{8'h00, cbc_pkg::CH_SPACE, 8'hFF, 8'h80, cbc_pkg::CH_NEWLINE,
               cbc_pkg::CH_SLASH, 8'h61, cbc_pkg::CH_SLASH, cbc_pkg::CH_SLASH, 8'h78,
               cbc_pkg::CH_NEWLINE, cbc_pkg::CH_SLASH, cbc_pkg::CH_STAR,
               cbc_pkg::CH_SLASH, 8'hC3, 8'hBF, cbc_pkg::CH_STAR, cbc_pkg::CH_SLASH,
               cbc_pkg::CH_SLASH};
    send_text(1'b1);
    // A text that ends inside a block comment.
    text_q = '{cbc_pkg::CH_SLASH, cbc_pkg::CH_STAR, cbc_pkg::CH_SPACE};
    send_text(1'b1);
    // A line comment opened by the final byte.
    text_q = '{cbc_pkg::CH_SLASH, cbc_pkg::CH_SLASH};
    send_text(1'b1);

    while (sent < RANDOM_BYTES) begin
      calm = ($urandom_range(0, 5) == 0);
      build_text();
      send_text($urandom_range(0, 3) != 0);
      if (!paused && sent > RANDOM_BYTES / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (12) @(posedge clk_i);
    board.flush_check();
    if (board.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
